>>> design/assert_macros.svh
// Assertion macros used by the checker file of the span generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds in the same cycle as the antecedent.
`define FCSG_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("span generator assertion failed");

// Holds in the cycle after the antecedent.
`define FCSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("span generator assertion failed");

`endif

>>> design/fcsg_pkg.sv
// Types and constants of the filled circle span generator.
`default_nettype none

package fcsg_pkg;

    // Field widths of the command and span words.
    localparam int CENTER_W = 10;
    localparam int RADIUS_W = 8;
    localparam int COLOR_W  = 8;
    localparam int COORD_W  = 12;

    // Stepping state widths.
    localparam int STEP_W   = 7;
    localparam int INC_W    = 9;
    localparam int ERR_W    = 10;
    localparam int TEST_W   = 12;

    // Guard on the number of steps of one circle.
    localparam int STEP_LIMIT = 64;
    localparam int CNT_W      = $clog2(STEP_LIMIT + 1);

    typedef logic [CENTER_W-1:0]       t_center;
    typedef logic [RADIUS_W-1:0]       t_radius;
    typedef logic [COLOR_W-1:0]        t_color;
    typedef logic signed [COORD_W-1:0] t_coord;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // latch a new command and start the walk
        logic step;   // register the current spans and advance one step
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;   // the current step is the final one of the circle
    } t_dp_sts;

    // One registered span word.
    typedef struct packed {
        t_coord wide_row_above;
        t_coord wide_row_below;
        t_coord wide_left;
        t_coord wide_right;
        t_coord narrow_row_above;
        t_coord narrow_row_below;
        t_coord narrow_left;
        t_coord narrow_right;
        t_color span_color;
        logic   last_step;
    } t_span_word;

endpackage

`default_nettype wire

>>> design/fcsg_if.sv
// Valid/ready channel interfaces for draw commands and span words.
`default_nettype none

// Draw command channel.
interface fcsg_cmd_if;
    logic               valid;
    logic               ready;
    fcsg_pkg::t_center  center_x;
    fcsg_pkg::t_center  center_y;
    fcsg_pkg::t_radius  circle_radius;
    fcsg_pkg::t_color   fill_color;

    modport source (output valid, center_x, center_y, circle_radius, fill_color,
                    input ready);
    modport sink   (input valid, center_x, center_y, circle_radius, fill_color,
                    output ready);
endinterface

// Span word channel.
interface fcsg_span_if;
    logic              valid;
    logic              ready;
    fcsg_pkg::t_coord  wide_row_above;
    fcsg_pkg::t_coord  wide_row_below;
    fcsg_pkg::t_coord  wide_left;
    fcsg_pkg::t_coord  wide_right;
    fcsg_pkg::t_coord  narrow_row_above;
    fcsg_pkg::t_coord  narrow_row_below;
    fcsg_pkg::t_coord  narrow_left;
    fcsg_pkg::t_coord  narrow_right;
    fcsg_pkg::t_color  span_color;
    logic              last_step;

    modport source (output valid, wide_row_above, wide_row_below, wide_left, wide_right,
                    narrow_row_above, narrow_row_below, narrow_left, narrow_right,
                    span_color, last_step,
                    input ready);
    modport sink   (input valid, wide_row_above, wide_row_below, wide_left, wide_right,
                    narrow_row_above, narrow_row_below, narrow_left, narrow_right,
                    span_color, last_step,
                    output ready);
endinterface

`default_nettype wire

>>> design/filled_circle_span_generator.sv
// Top level of the filled circle span generator.
//
// A draw command (center, radius, color) is taken, and the block then walks the midpoint
// circle from the clamped radius r, one step per cycle while the output word register can
// take a word, each step giving one word of four horizontal spans; the final word has
// last_step set. A circle has about r * 0.707 + 1 steps (r = 88 gives 63); the next command
// is accepted the cycle after the final word is registered. The error term advances once
// per step, and steps stall while the output word waits. The output word register lets a
// command be accepted while the final word of the previous circle still waits. Spans are
// not clipped; coordinates are 12-bit two's complement.
`default_nettype none

module filled_circle_span_generator #(
    parameter int MAX_RADIUS = 88
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fcsg_cmd_if.sink     i_cmd,
    fcsg_span_if.source  o_span
);

    fcsg_pkg::t_dp_cmd     dp_cmd;
    fcsg_pkg::t_dp_sts     dp_sts;
    fcsg_pkg::t_span_word  span_word;
    logic                  cmd_ready;
    logic                  out_valid;

    // Sequencing.
    fcsg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .i_out_ready (o_span.ready),
        .i_sts       (dp_sts),
        .o_cmd_ready (cmd_ready),
        .o_out_valid (out_valid),
        .o_dp_cmd    (dp_cmd)
    );

    // Stepping arithmetic and output word.
    fcsg_datapath #(
        .MAX_RADIUS (MAX_RADIUS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (dp_cmd),
        .i_center_x      (i_cmd.center_x),
        .i_center_y      (i_cmd.center_y),
        .i_circle_radius (i_cmd.circle_radius),
        .i_fill_color    (i_cmd.fill_color),
        .o_sts           (dp_sts),
        .o_span          (span_word)
    );

    assign i_cmd.ready             = cmd_ready;
    assign o_span.valid            = out_valid;
    assign o_span.wide_row_above   = span_word.wide_row_above;
    assign o_span.wide_row_below   = span_word.wide_row_below;
    assign o_span.wide_left        = span_word.wide_left;
    assign o_span.wide_right       = span_word.wide_right;
    assign o_span.narrow_row_above = span_word.narrow_row_above;
    assign o_span.narrow_row_below = span_word.narrow_row_below;
    assign o_span.narrow_left      = span_word.narrow_left;
    assign o_span.narrow_right     = span_word.narrow_right;
    assign o_span.span_color       = span_word.span_color;
    assign o_span.last_step        = span_word.last_step;

endmodule

`default_nettype wire

>>> design/fcsg_datapath.sv
// Midpoint circle stepping registers, span arithmetic and the output word register.
`default_nettype none

module fcsg_datapath #(
    parameter int MAX_RADIUS = 88
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  fcsg_pkg::t_dp_cmd     i_cmd,
    input  fcsg_pkg::t_center     i_center_x,
    input  fcsg_pkg::t_center     i_center_y,
    input  fcsg_pkg::t_radius     i_circle_radius,
    input  fcsg_pkg::t_color      i_fill_color,
    output fcsg_pkg::t_dp_sts     o_sts,
    output fcsg_pkg::t_span_word  o_span
);

    localparam int EXT_C = fcsg_pkg::COORD_W - fcsg_pkg::CENTER_W;
    localparam int EXT_S = fcsg_pkg::COORD_W - fcsg_pkg::STEP_W;
    localparam int EXT_T = fcsg_pkg::TEST_W - fcsg_pkg::ERR_W - 1;

    // Walk state.
    logic [fcsg_pkg::STEP_W-1:0]        r_step_x, n_step_x;
    logic [fcsg_pkg::STEP_W-1:0]        r_step_y, n_step_y;
    logic signed [fcsg_pkg::INC_W-1:0]  r_x_inc, n_x_inc;
    logic signed [fcsg_pkg::INC_W-1:0]  r_y_inc, n_y_inc;
    logic signed [fcsg_pkg::ERR_W-1:0]  r_err, n_err;
    logic [fcsg_pkg::CNT_W-1:0]         r_count, n_count;
    fcsg_pkg::t_center                  r_cx;
    fcsg_pkg::t_center                  r_cy;
    fcsg_pkg::t_color                   r_color;
    fcsg_pkg::t_span_word               r_span, n_span;

    fcsg_pkg::t_radius                  radius_clamped;
    logic signed [fcsg_pkg::ERR_W-1:0]  err_mid;
    logic signed [fcsg_pkg::TEST_W-1:0] err_test;
    fcsg_pkg::t_coord                   cx_ext, cy_ext, x_ext, y_ext;
    logic                               x_wrap;
    logic                               last_next;

    // Radius clamp at the command.
    assign radius_clamped = (i_circle_radius > fcsg_pkg::RADIUS_W'(MAX_RADIUS))
                          ? fcsg_pkg::RADIUS_W'(MAX_RADIUS) : i_circle_radius;

    // One midpoint step: y always advances, x steps in when the midpoint is outside.
    always_comb begin
        err_mid  = r_err + fcsg_pkg::ERR_W'(r_y_inc);
        err_test = $signed({{EXT_T{err_mid[fcsg_pkg::ERR_W-1]}}, err_mid, 1'b0})
                 + fcsg_pkg::TEST_W'(r_x_inc);
        n_step_y = r_step_y + 1'b1;
        n_y_inc  = r_y_inc + fcsg_pkg::INC_W'(2);
        n_count  = r_count + 1'b1;
        if (err_test > 0) begin
            n_step_x = r_step_x - 1'b1;
            n_err    = err_mid + fcsg_pkg::ERR_W'(r_x_inc);
            n_x_inc  = r_x_inc + fcsg_pkg::INC_W'(2);
        end else begin
            n_step_x = r_step_x;
            n_err    = err_mid;
            n_x_inc  = r_x_inc;
        end
        // A radius of zero steps x below zero, which ends the walk at once.
        x_wrap    = (err_test > 0) && (r_step_x == '0);
        last_next = x_wrap
                 || (n_step_x < n_step_y)
                 || (n_count >= fcsg_pkg::CNT_W'(fcsg_pkg::STEP_LIMIT));
    end

    // Span coordinates of the current step.
    always_comb begin
        cx_ext = {{EXT_C{1'b0}}, r_cx};
        cy_ext = {{EXT_C{1'b0}}, r_cy};
        x_ext  = {{EXT_S{1'b0}}, r_step_x};
        y_ext  = {{EXT_S{1'b0}}, r_step_y};
        n_span.wide_row_above   = cy_ext - y_ext;
        n_span.wide_row_below   = cy_ext + y_ext;
        n_span.wide_left        = cx_ext - x_ext;
        n_span.wide_right       = cx_ext + x_ext;
        n_span.narrow_row_above = cy_ext - x_ext;
        n_span.narrow_row_below = cy_ext + x_ext;
        n_span.narrow_left      = cx_ext - y_ext;
        n_span.narrow_right     = cx_ext + y_ext;
        n_span.span_color       = r_color;
        n_span.last_step        = last_next;
    end

    // Load a command or advance the walk; the span word is captured on each step.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx     <= '0;
            r_cy     <= '0;
            r_color  <= '0;
            r_step_x <= '0;
            r_step_y <= '0;
            r_x_inc  <= '0;
            r_y_inc  <= '0;
            r_err    <= '0;
            r_count  <= '0;
            r_span   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cx     <= i_center_x;
                r_cy     <= i_center_y;
                r_color  <= i_fill_color;
                r_step_x <= fcsg_pkg::STEP_W'(radius_clamped);
                r_step_y <= '0;
                r_x_inc  <= fcsg_pkg::INC_W'(1)
                          - $signed({1'b0, fcsg_pkg::STEP_W'(radius_clamped), 1'b0});
                r_y_inc  <= '0;
                r_err    <= '0;
                r_count  <= '0;
            end else if (i_cmd.step) begin
                r_step_x <= n_step_x;
                r_step_y <= n_step_y;
                r_x_inc  <= n_x_inc;
                r_y_inc  <= n_y_inc;
                r_err    <= n_err;
                r_count  <= n_count;
            end
            if (i_cmd.step) begin
                r_span <= n_span;
            end
        end
    end

    assign o_sts.last = last_next;
    assign o_span     = r_span;

endmodule

`default_nettype wire

>>> design/fcsg_ctrl.sv
// Controller of the span generator: command acceptance, stepping and output word valid.
`default_nettype none

module fcsg_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cmd_valid,
    input  wire                i_out_ready,
    input  fcsg_pkg::t_dp_sts  i_sts,
    output logic               o_cmd_ready,
    output logic               o_out_valid,
    output fcsg_pkg::t_dp_cmd  o_dp_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   step_en;

    // The output register can take a word when it is empty or being emptied.
    assign step_en = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_dp_cmd.load = 1'b1;
                    n_state       = ST_RUN;
                end
            end
            ST_RUN: begin
                if (step_en) begin
                    o_dp_cmd.step = 1'b1;
                    n_out_valid   = 1'b1;
                    if (i_sts.last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State and the output word valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

>>> design/fcsg_checker.sv
// Port-level checker of the span generator and its bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module fcsg_checker (
    input wire                i_clk,
    input wire                i_rst_n,
    input wire                i_cmd_valid,
    input wire                i_cmd_ready,
    input wire                i_out_valid,
    input wire                i_out_ready,
    input wire                i_last_step,
    input fcsg_pkg::t_coord   i_wide_row_above,
    input fcsg_pkg::t_coord   i_wide_row_below,
    input fcsg_pkg::t_coord   i_narrow_row_above,
    input fcsg_pkg::t_coord   i_narrow_row_below,
    input fcsg_pkg::t_color   i_span_color
);

    // A stalled word keeps its color.
    `FCSG_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_span_color))

    // An accepted command starts a walk, so no second command is taken next cycle.
    `FCSG_ASSERT_NEXT(a_busy_after_cmd, i_clk, i_rst_n, i_cmd_valid && i_cmd_ready, !i_cmd_ready)

    // While a word before the final one is shown, the circle is still being walked.
    `FCSG_ASSERT_SAME(a_busy_mid_circle, i_clk, i_rst_n, i_out_valid && !i_last_step, !i_cmd_ready)

    // A taken word before the final one is followed at once by the next word.
    `FCSG_ASSERT_NEXT(a_no_gap, i_clk, i_rst_n, i_out_valid && i_out_ready && !i_last_step, i_out_valid)

    // Both row pairs are symmetric about the center row.
    `FCSG_ASSERT_SAME(a_row_symmetry, i_clk, i_rst_n, i_out_valid, fcsg_pkg::COORD_W'(i_wide_row_above + i_wide_row_below) == fcsg_pkg::COORD_W'(i_narrow_row_above + i_narrow_row_below))

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_cmd_valid        (i_cmd.valid),
    .i_cmd_ready        (i_cmd.ready),
    .i_out_valid        (o_span.valid),
    .i_out_ready        (o_span.ready),
    .i_last_step        (o_span.last_step),
    .i_wide_row_above   (o_span.wide_row_above),
    .i_wide_row_below   (o_span.wide_row_below),
    .i_narrow_row_above (o_span.narrow_row_above),
    .i_narrow_row_below (o_span.narrow_row_below),
    .i_span_color       (o_span.span_color)
);

`default_nettype wire

>>> tb/tb_filled_circle_span_generator.sv
// Self-checking testbench for the filled circle span generator: random and directed discs.
`default_nettype none

module tb_filled_circle_span_generator;

    import fcsg_pkg::*;

    localparam int DISC_MAX_RADIUS = 88;
    localparam int RESET_CYCLES    = 11;
    localparam int RANDOM_DISCS    = 410;
    localparam int CYCLE_LIMIT     = 2_000_000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int MAX_IDLE        = 11;
    localparam int REPORT_LIMIT    = 10;

    // One queued draw command with its sender-side timing.
    typedef struct {
        t_center    cx;
        t_center    cy;
        t_radius    radius;
        t_color     color;
        int         gap;
        bit         drain_first;
    } disc_cmd_t;

    logic i_clk;
    logic i_rst_n;

    fcsg_cmd_if  cmd_ch ();
    fcsg_span_if span_ch ();

    disc_cmd_t   pending_discs[$];
    t_span_word  expected_spans[$];

    logic cmd_fire;
    logic span_fire;
    int   cycle_count;
    int   mismatch_count;
    int   discs_drawn;
    int   spans_checked;
    int   clamped_discs;
    int   sink_stall_left;
    bit   sink_no_stall;
    bit   gap_armed;
    int   gap_left;

    filled_circle_span_generator #(
        .MAX_RADIUS (DISC_MAX_RADIUS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_span  (span_ch)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Truncates a coordinate to the 12-bit two's complement span field.
    function automatic t_coord to_coord(input int v);
        return v[COORD_W-1:0];
    endfunction

    // Walks the midpoint circle of one command and queues every span word it yields.
    function automatic void expand_disc(input t_center cx, input t_center cy,
                                        input t_radius radius, input t_color color);
        int         r;
        int         x;
        int         y;
        int         x_step;
        int         y_step;
        int         err;
        int         steps;
        bit         walking;
        t_span_word w;
        r = (radius > DISC_MAX_RADIUS) ? DISC_MAX_RADIUS : int'(radius);
        x = r;
        y = 0;
        x_step = 1 - 2 * r;
        y_step = 0;
        err = 0;
        steps = 0;
        walking = 1'b1;
        while (walking) begin
            w.wide_row_above   = to_coord(int'(cy) - y);
            w.wide_row_below   = to_coord(int'(cy) + y);
            w.wide_left        = to_coord(int'(cx) - x);
            w.wide_right       = to_coord(int'(cx) + x);
            w.narrow_row_above = to_coord(int'(cy) - x);
            w.narrow_row_below = to_coord(int'(cy) + x);
            w.narrow_left      = to_coord(int'(cx) - y);
            w.narrow_right     = to_coord(int'(cx) + y);
            w.span_color       = color;
            steps++;
            // Advance one step; x moves in once the midpoint falls outside.
            y++;
            err += y_step;
            y_step += 2;
            if (err * 2 + x_step > 0) begin
                x--;
                err += x_step;
                x_step += 2;
            end
            if (x < y || steps >= STEP_LIMIT)
                walking = 1'b0;
            w.last_step = !walking;
            expected_spans.push_back(w);
        end
    endfunction

    task automatic queue_disc(input int cx, input int cy, input int radius, input int color,
                              input int gap, input bit drain_first);
        disc_cmd_t c;
        c.cx = cx[CENTER_W-1:0];
        c.cy = cy[CENTER_W-1:0];
        c.radius = radius[RADIUS_W-1:0];
        c.color = color[COLOR_W-1:0];
        c.gap = gap;
        c.drain_first = drain_first;
        pending_discs.push_back(c);
    endtask

    // Command driver: presents queued commands after their drawn gap (and drain, if marked), at the falling edge.
    always @(negedge i_clk) begin : drive_cmd
        logic next_valid;
        disc_cmd_t c;
        if (i_rst_n) begin
            next_valid = cmd_ch.valid && !cmd_fire;
            if (!next_valid && pending_discs.size() != 0) begin
                if (!gap_armed) begin
                    gap_left = pending_discs[0].gap;
                    gap_armed = 1'b1;
                end
                if (gap_left != 0) begin
                    gap_left--;
                end else if (!(pending_discs[0].drain_first && expected_spans.size() != 0)) begin
                    c = pending_discs.pop_front();
                    cmd_ch.center_x      <= c.cx;
                    cmd_ch.center_y      <= c.cy;
                    cmd_ch.circle_radius <= c.radius;
                    cmd_ch.fill_color    <= c.color;
                    next_valid = 1'b1;
                    gap_armed = 1'b0;
                end
            end
            cmd_ch.valid <= next_valid;
        end
    end

    // Span sink: after each taken word, hold ready low for a drawn number of cycles, unless stalling is toggled off.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ($urandom_range(0, 59) == 0)
                sink_no_stall = !sink_no_stall;
            if (span_fire)
                sink_stall_left = sink_no_stall ? 0 : $urandom_range(0, MAX_IDLE);
            if (sink_stall_left != 0) begin
                sink_stall_left--;
                span_ch.ready <= 1'b0;
            end else begin
                span_ch.ready <= 1'b1;
            end
        end
    end

    // Monitor: checks taken span words, then predicts the words of a taken command.
    always @(posedge i_clk) begin : watch_ports
        t_span_word got;
        t_span_word want;
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d span words outstanding",
                     cycle_count, expected_spans.size());
            $display("Simulation FAILED");
            $finish;
        end
        cmd_fire  <= i_rst_n && cmd_ch.valid && cmd_ch.ready;
        span_fire <= i_rst_n && span_ch.valid && span_ch.ready;
        if (i_rst_n && span_ch.valid && span_ch.ready) begin
            got.wide_row_above   = span_ch.wide_row_above;
            got.wide_row_below   = span_ch.wide_row_below;
            got.wide_left        = span_ch.wide_left;
            got.wide_right       = span_ch.wide_right;
            got.narrow_row_above = span_ch.narrow_row_above;
            got.narrow_row_below = span_ch.narrow_row_below;
            got.narrow_left      = span_ch.narrow_left;
            got.narrow_right     = span_ch.narrow_right;
            got.span_color       = span_ch.span_color;
            got.last_step        = span_ch.last_step;
            if (expected_spans.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("Unexpected span word at cycle %0d", cycle_count);
            end else begin
                want = expected_spans.pop_front();
                spans_checked++;
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("Span word %0d mismatch at cycle %0d", spans_checked,
                                 cycle_count);
                        $display("  expected wide %0d %0d [%0d..%0d] narrow %0d %0d [%0d..%0d] c=%0d l=%0d",
                                 want.wide_row_above, want.wide_row_below, want.wide_left,
                                 want.wide_right, want.narrow_row_above, want.narrow_row_below,
                                 want.narrow_left, want.narrow_right, want.span_color,
                                 want.last_step);
                        $display("  actual   wide %0d %0d [%0d..%0d] narrow %0d %0d [%0d..%0d] c=%0d l=%0d",
                                 got.wide_row_above, got.wide_row_below, got.wide_left,
                                 got.wide_right, got.narrow_row_above, got.narrow_row_below,
                                 got.narrow_left, got.narrow_right, got.span_color,
                                 got.last_step);
                    end
                end
            end
        end
        if (i_rst_n && cmd_ch.valid && cmd_ch.ready) begin
            discs_drawn++;
            if (cmd_ch.circle_radius > DISC_MAX_RADIUS)
                clamped_discs++;
            expand_disc(cmd_ch.center_x, cmd_ch.center_y, cmd_ch.circle_radius,
                        cmd_ch.fill_color);
        end
    end

    // Stimulus and end of run.
    initial begin
        int  sel;
        int  radius;
        bit  quick;
        i_rst_n = 1'b0;
        cmd_ch.valid = 1'b0;
        cmd_ch.center_x = '0;
        cmd_ch.center_y = '0;
        cmd_ch.circle_radius = '0;
        cmd_ch.fill_color = '0;
        span_ch.ready = 1'b0;
        cmd_fire = 1'b0;
        span_fire = 1'b0;
        cycle_count = 0;
        mismatch_count = 0;
        discs_drawn = 0;
        spans_checked = 0;
        clamped_discs = 0;
        sink_stall_left = 0;
        sink_no_stall = 1'b0;
        gap_armed = 1'b0;
        gap_left = 0;
        quick = 1'b0;

        // Directed discs: zero and unit radii, the clamp boundary, corners and color extremes.
        queue_disc(0, 0, 0, 0, 0, 1'b0);
        queue_disc(1023, 1023, 0, 255, 0, 1'b0);
        queue_disc(512, 512, 1, 170, 0, 1'b0);
        queue_disc(512, 512, 2, 85, 0, 1'b0);
        queue_disc(0, 0, 88, 1, 0, 1'b0);
        queue_disc(1023, 1023, 88, 254, 3, 1'b1);
        queue_disc(100, 900, 89, 128, 0, 1'b0);
        queue_disc(900, 100, 255, 127, 0, 1'b0);
        queue_disc(0, 1023, 255, 0, 0, 1'b1);
        queue_disc(1023, 0, 87, 255, 5, 1'b0);
        queue_disc(341, 682, 3, 15, 0, 1'b0);
        queue_disc(682, 341, 5, 240, 0, 1'b0);
        queue_disc(5, 5, 10, 51, 0, 1'b0);
        queue_disc(1018, 1018, 10, 204, 11, 1'b0);
        queue_disc(50, 60, 128, 77, 0, 1'b0);
        queue_disc(60, 50, 64, 178, 0, 1'b1);
        queue_disc(0, 512, 44, 33, 0, 1'b0);
        queue_disc(1023, 512, 4, 222, 0, 1'b0);

        // Random discs: mostly small radii, some large, a few past the clamp.
        for (int i = 0; i < RANDOM_DISCS; i++) begin
            if (i % 30 == 0)
                quick = ($urandom_range(0, 2) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 55)
                radius = $urandom_range(0, 12);
            else if (sel < 80)
                radius = $urandom_range(13, 40);
            else if (sel < 92)
                radius = $urandom_range(41, DISC_MAX_RADIUS);
            else
                radius = $urandom_range(DISC_MAX_RADIUS + 1, 255);
            queue_disc($urandom_range(0, 1023), $urandom_range(0, 1023), radius,
                       $urandom_range(0, 255), quick ? 0 : $urandom_range(0, MAX_IDLE),
                       ($urandom_range(0, 49) == 0));
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Wait for every command to be taken and every span word to arrive.
        while (pending_discs.size() != 0 || cmd_ch.valid)
            @(posedge i_clk);
        while (expected_spans.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Drew %0d discs (%0d with clamped radius), checked %0d span words.",
                 discs_drawn, clamped_discs, spans_checked);
        $display("Mismatches: %0d, cycles: %0d.", mismatch_count, cycle_count);
        if (mismatch_count == 0 && expected_spans.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
